// File: rtl/nec_ir_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// NEC IR decoder package
// Item kinds, register indexes, reset values and the pulse window test.
// ---------------------------------------------------------------------------
package nec_ir_pkg;

  typedef logic [1:0]  mode_t;
  typedef logic [2:0]  cfg_index_t;
  typedef logic [31:0] window_t;
  typedef logic [15:0] ticks_t;

  localparam mode_t MODE_OVERFLOW = 2'd0;
  localparam mode_t MODE_EDGE     = 2'd1;
  localparam mode_t MODE_SCAN     = 2'd2;

  localparam cfg_index_t REG_BIT_ZERO_WINDOW = 3'd0;
  localparam cfg_index_t REG_BIT_ONE_WINDOW  = 3'd1;
  localparam cfg_index_t REG_REPEAT_WINDOW   = 3'd2;
  localparam cfg_index_t REG_LEADER_WINDOW   = 3'd3;
  localparam cfg_index_t REG_OVERFLOW_PERIOD = 3'd4;
  localparam cfg_index_t REG_DEVICE_ADDRESS  = 3'd5;

  localparam window_t RST_BIT_ZERO_WINDOW = {16'd800, 16'd300};
  localparam window_t RST_BIT_ONE_WINDOW  = {16'd1800, 16'd1400};
  localparam window_t RST_REPEAT_WINDOW   = {16'd3000, 16'd2000};
  localparam window_t RST_LEADER_WINDOW   = {16'd4700, 16'd4200};
  localparam ticks_t  RST_OVERFLOW_PERIOD = 16'd10000;
  localparam logic [7:0] RST_DEVICE_ADDRESS = 8'h00;

  localparam logic [3:0] SAT_TICKS     = 4'd15;
  localparam logic [3:0] TIMEOUT_TICKS = 4'd5;
  localparam logic [31:0] FRAME_MSB    = 32'h8000_0000;

  // A window matches strictly between its minimum and its maximum.
  function automatic logic in_window(input window_t win, input ticks_t t);
    return (t > win[15:0]) && (t < win[31:16]);
  endfunction

endpackage

// File: rtl/nec_ir_pulse_decoder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// NEC IR pulse decoder core
// Decodes NEC remote frames from timer overflow ticks, pin edges and scans.
// ---------------------------------------------------------------------------
// Each input beat carries mode, pin_level and capture_count on a valid/ready
// channel. Every accepted beat produces exactly one output beat with
// key_value (validated command of a scan, zero otherwise) and key_count
// (repeat codes counted since the last leader).
// All work for a beat is done in the cycle it is accepted; the result sits
// in the output register from the next cycle. One beat per cycle is sustained
// while out_ready is high, bounded only by the single output register.
// in_ready is high whenever the output register is empty or being drained,
// so a new beat is taken in the same cycle a held result is taken.
// When the receiver stalls, the result holds and in_ready drops until the
// output beat is accepted.
// The configuration port writes a register on every cycle cfg_write is high;
// indexes beyond the list are ignored. Write it only while the block idles.
// Reset restores the default windows, period and address, and clears the
// decoder state and out_valid; key_value and key_count are not reset.
// ---------------------------------------------------------------------------
module nec_ir_pulse_decoder_core
  import nec_ir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic        pin_level,
  input  logic [15:0] capture_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  key_value,
  output logic [7:0]  key_count,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  window_t    bit_zero_window;
  window_t    bit_one_window;
  window_t    repeat_window;
  window_t    leader_window;
  ticks_t     overflow_period;
  logic [7:0] device_address;

  ticks_t      rise_capture, rise_capture_next;
  logic [3:0]  overflow_ticks, overflow_ticks_next;
  logic        high_pending, high_pending_next;
  logic        leader_seen, leader_seen_next;
  logic        frame_ready, frame_ready_next;
  logic [31:0] frame_bits, frame_bits_next;
  logic [7:0]  repeat_count, repeat_count_next;
  logic [7:0]  key_next;

  logic        in_fire;
  logic [19:0] span;
  ticks_t      high_time;
  logic [3:0]  ticks_inc;
  logic [7:0]  frame_cmd;
  logic        frame_ok;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign span      = overflow_period * overflow_ticks;
  assign high_time = span[15:0] + capture_count - rise_capture;
  assign ticks_inc = (overflow_ticks < SAT_TICKS) ? overflow_ticks + 4'd1 : overflow_ticks;
  assign frame_cmd = frame_bits[23:16];
  assign frame_ok  = (frame_bits[7:0] == ~frame_bits[15:8])
                     && (frame_bits[7:0] == device_address)
                     && (frame_cmd == ~frame_bits[31:24]);

  always_comb begin
    rise_capture_next   = rise_capture;
    overflow_ticks_next = overflow_ticks;
    high_pending_next   = high_pending;
    leader_seen_next    = leader_seen;
    frame_ready_next    = frame_ready;
    frame_bits_next     = frame_bits;
    repeat_count_next   = repeat_count;
    key_next            = 8'h00;
    case (mode)
      MODE_OVERFLOW: begin
        overflow_ticks_next = ticks_inc;
        if (ticks_inc > TIMEOUT_TICKS) begin
          leader_seen_next  = 1'b0;
          repeat_count_next = 8'h00;
        end
      end
      MODE_EDGE: begin
        if (pin_level) begin
          rise_capture_next   = capture_count;
          overflow_ticks_next = 4'd0;
          high_pending_next   = 1'b1;
        end else begin
          high_pending_next = 1'b0;
          if (high_pending) begin
            if (leader_seen) begin
              if (in_window(bit_zero_window, high_time)) begin
                frame_bits_next = {1'b0, frame_bits[31:1]};
              end else if (in_window(bit_one_window, high_time)) begin
                frame_bits_next = {1'b0, frame_bits[31:1]} | FRAME_MSB;
              end else if (in_window(repeat_window, high_time)) begin
                frame_ready_next    = 1'b1;
                repeat_count_next   = repeat_count + 8'd1;
                overflow_ticks_next = 4'd0;
              end
            end else if (in_window(leader_window, high_time)) begin
              leader_seen_next  = 1'b1;
              repeat_count_next = 8'h00;
            end
          end
        end
      end
      MODE_SCAN: begin
        if (frame_ready) begin
          frame_ready_next = 1'b0;
          key_next = frame_ok ? frame_cmd : 8'h00;
          if (!frame_ok || frame_cmd == 8'h00 || !leader_seen) begin
            repeat_count_next = 8'h00;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_zero_window <= RST_BIT_ZERO_WINDOW;
      bit_one_window  <= RST_BIT_ONE_WINDOW;
      repeat_window   <= RST_REPEAT_WINDOW;
      leader_window   <= RST_LEADER_WINDOW;
      overflow_period <= RST_OVERFLOW_PERIOD;
      device_address  <= RST_DEVICE_ADDRESS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BIT_ZERO_WINDOW: bit_zero_window <= cfg_data;
        REG_BIT_ONE_WINDOW:  bit_one_window  <= cfg_data;
        REG_REPEAT_WINDOW:   repeat_window   <= cfg_data;
        REG_LEADER_WINDOW:   leader_window   <= cfg_data;
        REG_OVERFLOW_PERIOD: overflow_period <= cfg_data[15:0];
        REG_DEVICE_ADDRESS:  device_address  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_capture   <= 16'h0000;
      overflow_ticks <= 4'd0;
      high_pending   <= 1'b0;
      leader_seen    <= 1'b0;
      frame_ready    <= 1'b0;
      frame_bits     <= 32'h0000_0000;
      repeat_count   <= 8'h00;
      out_valid      <= 1'b0;
    end else begin
      if (in_fire) begin
        rise_capture   <= rise_capture_next;
        overflow_ticks <= overflow_ticks_next;
        high_pending   <= high_pending_next;
        leader_seen    <= leader_seen_next;
        frame_ready    <= frame_ready_next;
        frame_bits     <= frame_bits_next;
        repeat_count   <= repeat_count_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_value <= key_next;
      key_count <= repeat_count_next;
    end
  end

  a_non_scan_key_zero: assert property (@(posedge clk) disable iff (rst)
    (in_fire && mode != MODE_SCAN) |=> (key_value == 8'h00))
    else $error("non-scan beat produced a nonzero key");

  a_scan_without_frame: assert property (@(posedge clk) disable iff (rst)
    (in_fire && mode == MODE_SCAN && !frame_ready) |=> (key_value == 8'h00))
    else $error("scan without a ready frame produced a key");

  a_rise_arms: assert property (@(posedge clk) disable iff (rst)
    (in_fire && mode == MODE_EDGE && pin_level)
      |=> (high_pending && overflow_ticks == 4'd0 && rise_capture == $past(capture_count)))
    else $error("rising edge did not arm the high-time measurement");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> ($stable(frame_bits) && $stable(repeat_count) && $stable(leader_seen)))
    else $error("decoder state changed without an accepted beat");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (key_count == repeat_count))
    else $error("reported count differs from the repeat counter");

endmodule
